[src/vp8_reference_slot_manager_core_macros.svh]
// assertion helpers, clocked on clk and disabled during rst_n low
`ifndef VP8_REFERENCE_SLOT_MANAGER_CORE_MACROS_SVH
`define VP8_REFERENCE_SLOT_MANAGER_CORE_MACROS_SVH

// same-cycle implication
`define VRSM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VRSM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/vrsm_pkg.sv]
`default_nettype none
package vrsm_pkg;

  localparam int NUM_SLOTS = 3;
  localparam int NUM_CAND  = 4;
  localparam int OUT_BITS  = 16;

  localparam int SLOT_LAST   = 0;
  localparam int SLOT_GOLDEN = 1;
  localparam int SLOT_ALT    = 2;
  localparam int CAND_CUR    = 3;

  localparam logic KIND_REPORT  = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_NOREF = 1'b1;

  typedef enum logic [1:0] {
    COPY_NONE  = 2'd0,
    COPY_LAST  = 2'd1,
    COPY_OTHER = 2'd2,
    COPY_RSVD  = 2'd3
  } copy_t;

  typedef struct packed {
    logic  key_frame;
    logic  refresh_last;
    logic  refresh_golden;
    logic  refresh_alt;
    copy_t copy_to_golden;
    copy_t copy_to_alt;
  } frame_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_REPORT,
    ST_RELEASE
  } state_t;

endpackage
`default_nettype wire

[src/vp8_reference_slot_manager_core.sv]
// accepted frame: release scan, then the reference report; a rejected P frame goes straight to its report
// releases follow the report one per cycle while out_ready is high
// a new frame is taken only in idle, once the last word of the previous run has been taken
// the release scan tests the four candidates in four steps through the shared compare unit
// reset: synchronous active-low rst_n empties all three slots (index 0) and returns to idle
`default_nettype none
`include "vp8_reference_slot_manager_core_macros.svh"
module vp8_reference_slot_manager_core import vrsm_pkg::*; #(
  parameter int INDEX_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // frame word in
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] in_frame_index,
  input  wire logic        in_key_frame,
  input  wire logic        in_refresh_last,
  input  wire logic        in_refresh_golden,
  input  wire logic        in_refresh_alt,
  input  wire logic [1:0]  in_copy_to_golden,
  input  wire logic [1:0]  in_copy_to_alt,
  // result word out
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_result_kind,
  output logic             out_status,
  output logic [15:0]      out_ref_last,
  output logic [15:0]      out_ref_golden,
  output logic [15:0]      out_ref_alt,
  output logic [15:0]      out_release_index,
  output logic             out_last_of_run
);

  // sequencer state
  state_t state_r, state_nxt;
  logic [1:0] cand_r, cand_nxt;                 // candidate under test in scan
  logic [NUM_CAND-1:0] rel_mask_r, rel_mask_nxt; // candidates to release

  // slot file: last, golden, alternate
  logic [NUM_SLOTS-1:0]                 slot_valid_r, slot_valid_nxt;
  logic [NUM_SLOTS-1:0][INDEX_BITS-1:0] slot_frame_r, slot_frame_nxt;

  // snapshot of the slots before update, plus the current frame as last candidate
  logic [NUM_CAND-1:0]                 old_valid_r, old_valid_nxt;
  logic [NUM_CAND-1:0][INDEX_BITS-1:0] old_frame_r, old_frame_nxt;

  // report word held until taken
  logic        status_r, status_nxt;
  logic [15:0] rep_last_r, rep_last_nxt;
  logic [15:0] rep_golden_r, rep_golden_nxt;
  logic [15:0] rep_alt_r, rep_alt_nxt;

  // incoming frame
  frame_ctl_t           in_ctl;
  logic [INDEX_BITS-1:0] cur;
  logic                 in_fire;
  logic                 reject;

  // update and compare results
  logic [NUM_SLOTS-1:0]                 upd_valid;
  logic [NUM_SLOTS-1:0][INDEX_BITS-1:0] upd_frame;
  logic [INDEX_BITS-1:0]                cand_frame;
  logic                                 cand_used;

  // release selection
  logic [1:0]          rel_sel;
  logic [NUM_CAND-1:0] rel_low;
  logic [NUM_CAND-1:0] rel_rest;
  logic                out_fire;

  assign in_ctl.key_frame      = in_key_frame;
  assign in_ctl.refresh_last   = in_refresh_last;
  assign in_ctl.refresh_golden = in_refresh_golden;
  assign in_ctl.refresh_alt    = in_refresh_alt;
  assign in_ctl.copy_to_golden = copy_t'(in_copy_to_golden);
  assign in_ctl.copy_to_alt    = copy_t'(in_copy_to_alt);

  // stored indices live at INDEX_BITS
  assign cur = INDEX_BITS'(in_frame_index);

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = (state_r == ST_REPORT) || (state_r == ST_RELEASE);
  assign out_fire  = out_valid && out_ready;

  // p frame without a last reference is refused
  assign reject = !in_key_frame && !slot_valid_r[SLOT_LAST];

  vrsm_update #(
    .INDEX_BITS(INDEX_BITS)
  ) u_update (
    .ctl       (in_ctl),
    .cur       (cur),
    .valid_in  (slot_valid_r),
    .frame_in  (slot_frame_r),
    .valid_out (upd_valid),
    .frame_out (upd_frame)
  );

  // one candidate per scan cycle against the updated slots
  assign cand_frame = old_frame_r[cand_r];

  vrsm_match #(
    .INDEX_BITS(INDEX_BITS)
  ) u_match (
    .cand       (cand_frame),
    .slot_valid (slot_valid_r),
    .slot_frame (slot_frame_r),
    .used       (cand_used)
  );

  // lowest pending candidate goes out first
  assign rel_low  = rel_mask_r & (~rel_mask_r + NUM_CAND'(1));
  assign rel_rest = rel_mask_r & ~rel_low;

  always_comb begin
    if (rel_mask_r[0]) begin
      rel_sel = 2'd0;
    end else if (rel_mask_r[1]) begin
      rel_sel = 2'd1;
    end else if (rel_mask_r[2]) begin
      rel_sel = 2'd2;
    end else begin
      rel_sel = 2'd3;
    end
  end

  // output word mux
  always_comb begin
    out_result_kind   = KIND_REPORT;
    out_status        = status_r;
    out_ref_last      = rep_last_r;
    out_ref_golden    = rep_golden_r;
    out_ref_alt       = rep_alt_r;
    out_release_index = '0;
    out_last_of_run   = (rel_mask_r == '0);
    if (state_r == ST_RELEASE) begin
      out_result_kind   = KIND_RELEASE;
      out_status        = STATUS_OK;
      out_ref_last      = '0;
      out_ref_golden    = '0;
      out_ref_alt       = '0;
      out_release_index = OUT_BITS'(old_frame_r[rel_sel]);
      out_last_of_run   = (rel_rest == '0);
    end
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    cand_nxt       = cand_r;
    rel_mask_nxt   = rel_mask_r;
    slot_valid_nxt = slot_valid_r;
    slot_frame_nxt = slot_frame_r;
    old_valid_nxt  = old_valid_r;
    old_frame_nxt  = old_frame_r;
    status_nxt     = status_r;
    rep_last_nxt   = rep_last_r;
    rep_golden_nxt = rep_golden_r;
    rep_alt_nxt    = rep_alt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cand_nxt      = '0;
          rel_mask_nxt  = '0;
          old_valid_nxt = {1'b1, slot_valid_r};
          old_frame_nxt = {cur, slot_frame_r};
          if (reject) begin
            // refused frame: zero refs, slots untouched, no scan
            status_nxt     = STATUS_NOREF;
            rep_last_nxt   = '0;
            rep_golden_nxt = '0;
            rep_alt_nxt    = '0;
            state_nxt      = ST_REPORT;
          end else begin
            // empty slot on a key frame points at the frame itself
            status_nxt     = STATUS_OK;
            rep_last_nxt   = OUT_BITS'((!slot_valid_r[SLOT_LAST] && in_key_frame)
                                       ? cur : slot_frame_r[SLOT_LAST]);
            rep_golden_nxt = OUT_BITS'((!slot_valid_r[SLOT_GOLDEN] && in_key_frame)
                                       ? cur : slot_frame_r[SLOT_GOLDEN]);
            rep_alt_nxt    = OUT_BITS'((!slot_valid_r[SLOT_ALT] && in_key_frame)
                                       ? cur : slot_frame_r[SLOT_ALT]);
            slot_valid_nxt = upd_valid;
            slot_frame_nxt = upd_frame;
            state_nxt      = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (old_valid_r[cand_r] && !cand_used) begin
          rel_mask_nxt[cand_r] = 1'b1;
        end
        cand_nxt = cand_r + 2'd1;
        if (cand_r == 2'(CAND_CUR)) begin
          state_nxt = ST_REPORT;
        end
      end
      ST_REPORT: begin
        if (out_fire) begin
          state_nxt = (rel_mask_r == '0) ? ST_IDLE : ST_RELEASE;
        end
      end
      ST_RELEASE: begin
        if (out_fire) begin
          rel_mask_nxt = rel_rest;
          if (rel_rest == '0) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cand_r       <= '0;
      rel_mask_r   <= '0;
      slot_valid_r <= '0;
      slot_frame_r <= '0;
      old_valid_r  <= '0;
    end else begin
      state_r      <= state_nxt;
      cand_r       <= cand_nxt;
      rel_mask_r   <= rel_mask_nxt;
      slot_valid_r <= slot_valid_nxt;
      slot_frame_r <= slot_frame_nxt;
      old_valid_r  <= old_valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    old_frame_r  <= old_frame_nxt;
    status_r     <= status_nxt;
    rep_last_r   <= rep_last_nxt;
    rep_golden_r <= rep_golden_nxt;
    rep_alt_r    <= rep_alt_nxt;
  end

  // checks
  `VRSM_ASSERT_NOW(a_no_overlap, in_ready, !out_valid, "input taken while a word is pending")
  `VRSM_ASSERT_NEXT(a_accept_path, in_fire,
    (state_r == ST_SCAN) || (state_r == ST_REPORT), "accepted frame did not start")
  `VRSM_ASSERT_NOW(a_reject_alone,
    out_valid && (state_r == ST_REPORT) && (status_r == STATUS_NOREF),
    out_last_of_run && (rel_mask_r == '0), "refused frame with releases")
  `VRSM_ASSERT_NOW(a_mask_old_valid, 1'b1, (rel_mask_r & ~old_valid_r) == '0,
    "release of a slot that was empty")
  `VRSM_ASSERT_NEXT(a_release_shrinks, (state_r == ST_RELEASE) && out_fire,
    $countones(rel_mask_r) == $countones($past(rel_mask_r)) - 1, "release count did not drop")

endmodule
`default_nettype wire

[src/vrsm_match.sv]
`default_nettype none
// shared compare unit: is the candidate index held by any valid slot
module vrsm_match import vrsm_pkg::*; #(
  parameter int INDEX_BITS = 16
) (
  input  wire logic [INDEX_BITS-1:0]                cand,
  input  wire logic [NUM_SLOTS-1:0]                 slot_valid,
  input  wire logic [NUM_SLOTS-1:0][INDEX_BITS-1:0] slot_frame,
  output logic                                      used
);

  always_comb begin
    used = 1'b0;
    for (int j = 0; j < NUM_SLOTS; j++) begin
      if (slot_valid[j] && (slot_frame[j] == cand)) begin
        used = 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[src/vrsm_update.sv]
`default_nettype none
// refresh and copy rules for the three slots
module vrsm_update import vrsm_pkg::*; #(
  parameter int INDEX_BITS = 16
) (
  input  wire frame_ctl_t                           ctl,
  input  wire logic [INDEX_BITS-1:0]                cur,
  input  wire logic [NUM_SLOTS-1:0]                 valid_in,
  input  wire logic [NUM_SLOTS-1:0][INDEX_BITS-1:0] frame_in,
  output logic      [NUM_SLOTS-1:0]                 valid_out,
  output logic      [NUM_SLOTS-1:0][INDEX_BITS-1:0] frame_out
);

  always_comb begin
    valid_out = valid_in;
    frame_out = frame_in;
    if (ctl.key_frame) begin
      valid_out = '1;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        frame_out[i] = cur;
      end
    end else begin
      if (ctl.refresh_last) begin
        valid_out[SLOT_LAST] = 1'b1;
        frame_out[SLOT_LAST] = cur;
      end
      // golden: refresh wins over copy, copy code 3 is a no-op
      if (ctl.refresh_golden) begin
        valid_out[SLOT_GOLDEN] = 1'b1;
        frame_out[SLOT_GOLDEN] = cur;
      end else if (ctl.copy_to_golden == COPY_LAST) begin
        valid_out[SLOT_GOLDEN] = 1'b1;
        frame_out[SLOT_GOLDEN] = frame_in[SLOT_LAST];
      end else if (ctl.copy_to_golden == COPY_OTHER) begin
        valid_out[SLOT_GOLDEN] = 1'b1;
        frame_out[SLOT_GOLDEN] = frame_in[SLOT_ALT];
      end
      if (ctl.refresh_alt) begin
        valid_out[SLOT_ALT] = 1'b1;
        frame_out[SLOT_ALT] = cur;
      end else if (ctl.copy_to_alt == COPY_LAST) begin
        valid_out[SLOT_ALT] = 1'b1;
        frame_out[SLOT_ALT] = frame_in[SLOT_LAST];
      end else if (ctl.copy_to_alt == COPY_OTHER) begin
        valid_out[SLOT_ALT] = 1'b1;
        frame_out[SLOT_ALT] = frame_in[SLOT_GOLDEN];
      end
    end
  end

endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
module tb_top import vrsm_pkg::*; ();

  localparam int IDX_BITS       = 16;
  localparam int RANDOM_FRAMES  = 162;
  localparam int MAX_WAIT       = 12;
  // no word accepted on either side for this many cycles means a hang
  localparam int QUIET_LIMIT    = 1000;
  // one long back-pressure stretch from the result side
  localparam int HOLD_CYCLES    = 200;
  localparam int HOLD_AT_RESULT = 60;
  // room after the last expected result for stray words to show up
  localparam int TAIL_CYCLES    = 30;
  localparam int MAX_PRINTED    = 60;

  // one frame word plus the idle cycles the sender spends before offering it
  typedef struct {
    logic [15:0] frame_index;
    logic        key_frame;
    logic        refresh_last;
    logic        refresh_golden;
    logic        refresh_alt;
    copy_t       copy_to_golden;
    copy_t       copy_to_alt;
    int          gap;
  } frame_word_t;

  typedef struct {
    logic        kind;
    logic        status;
    logic [15:0] ref_last;
    logic [15:0] ref_golden;
    logic [15:0] ref_alt;
    logic [15:0] release_index;
    logic        last_of_run;
  } result_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;

  logic        in_valid = 1'b0;
  wire         in_ready;
  logic [15:0] in_frame_index = '0;
  logic        in_key_frame = 1'b0;
  logic        in_refresh_last = 1'b0;
  logic        in_refresh_golden = 1'b0;
  logic        in_refresh_alt = 1'b0;
  logic [1:0]  in_copy_to_golden = '0;
  logic [1:0]  in_copy_to_alt = '0;

  wire         out_valid;
  logic        out_ready = 1'b0;
  wire         out_result_kind;
  wire         out_status;
  wire  [15:0] out_ref_last;
  wire  [15:0] out_ref_golden;
  wire  [15:0] out_ref_alt;
  wire  [15:0] out_release_index;
  wire         out_last_of_run;

  // frames waiting to be offered, and results the slot predictor says are due
  frame_word_t  frame_q[$];
  result_word_t results_due[$];

  // predictor copy of the three reference slots, ordered last, golden, alternate
  logic                held_valid[NUM_SLOTS];
  logic [IDX_BITS-1:0] held_index[NUM_SLOTS];

  int n_frames     = 0;
  int frames_taken = 0;
  int results_seen = 0;
  int err_cnt      = 0;

  vp8_reference_slot_manager_core #(
    .INDEX_BITS(IDX_BITS)
  ) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_frame_index    (in_frame_index),
    .in_key_frame      (in_key_frame),
    .in_refresh_last   (in_refresh_last),
    .in_refresh_golden (in_refresh_golden),
    .in_refresh_alt    (in_refresh_alt),
    .in_copy_to_golden (in_copy_to_golden),
    .in_copy_to_alt    (in_copy_to_alt),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_result_kind   (out_result_kind),
    .out_status        (out_status),
    .out_ref_last      (out_ref_last),
    .out_ref_golden    (out_ref_golden),
    .out_ref_alt       (out_ref_alt),
    .out_release_index (out_release_index),
    .out_last_of_run   (out_last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    err_cnt++;
    // keep the log short when the block is badly broken, the count stays exact
    if (err_cnt <= MAX_PRINTED)
      $display("tb_top: mismatch on %s, got %h want %h at %0t", what, got, want, $time);
  endtask

  // works out the report and the releases for one accepted frame word and
  // moves the slot copy on by the refresh and copy rules
  task automatic predict_frame(input frame_word_t w);
    result_word_t        run[$];
    result_word_t        r;
    logic                prev_held[NUM_CAND];
    logic [IDX_BITS-1:0] prev_idx[NUM_CAND];
    logic [IDX_BITS-1:0] cur;
    logic                still_held;
    cur = w.frame_index;
    r = '{default: '0};
    r.kind = KIND_REPORT;
    // inter frame without a last reference: rejected, slots left alone
    if (!w.key_frame && !held_valid[SLOT_LAST]) begin
      r.status = STATUS_NOREF;
      r.last_of_run = 1'b1;
      results_due.push_back(r);
      return;
    end
    for (int s = 0; s < NUM_SLOTS; s++) begin
      prev_held[s] = held_valid[s];
      prev_idx[s]  = held_index[s];
    end
    // the frame itself is always a release candidate
    prev_held[CAND_CUR] = 1'b1;
    prev_idx[CAND_CUR]  = cur;
    // an empty slot on a key frame points at the frame itself
    r.ref_last   = (w.key_frame && !held_valid[SLOT_LAST])   ? cur : held_index[SLOT_LAST];
    r.ref_golden = (w.key_frame && !held_valid[SLOT_GOLDEN]) ? cur : held_index[SLOT_GOLDEN];
    r.ref_alt    = (w.key_frame && !held_valid[SLOT_ALT])    ? cur : held_index[SLOT_ALT];
    run.push_back(r);

    if (w.key_frame) begin
      // key frame fills every slot, refresh and copy fields ignored
      for (int s = 0; s < NUM_SLOTS; s++) begin
        held_valid[s] = 1'b1;
        held_index[s] = cur;
      end
    end else begin
      if (w.refresh_last) begin
        held_valid[SLOT_LAST] = 1'b1;
        held_index[SLOT_LAST] = cur;
      end
      // refresh wins over copy, copies read the slots as they were
      if (w.refresh_golden) begin
        held_valid[SLOT_GOLDEN] = 1'b1;
        held_index[SLOT_GOLDEN] = cur;
      end else begin
        case (w.copy_to_golden)
          COPY_LAST: begin
            held_valid[SLOT_GOLDEN] = 1'b1;
            held_index[SLOT_GOLDEN] = prev_idx[SLOT_LAST];
          end
          COPY_OTHER: begin
            held_valid[SLOT_GOLDEN] = 1'b1;
            held_index[SLOT_GOLDEN] = prev_idx[SLOT_ALT];
          end
          default: ;
        endcase
      end
      if (w.refresh_alt) begin
        held_valid[SLOT_ALT] = 1'b1;
        held_index[SLOT_ALT] = cur;
      end else begin
        case (w.copy_to_alt)
          COPY_LAST: begin
            held_valid[SLOT_ALT] = 1'b1;
            held_index[SLOT_ALT] = prev_idx[SLOT_LAST];
          end
          COPY_OTHER: begin
            held_valid[SLOT_ALT] = 1'b1;
            held_index[SLOT_ALT] = prev_idx[SLOT_GOLDEN];
          end
          default: ;
        endcase
      end
    end

    // release scan: old last, old golden, old alternate, then the frame,
    // one release per candidate, duplicates kept
    for (int c = 0; c < NUM_CAND; c++) begin
      if (prev_held[c]) begin
        still_held = 1'b0;
        for (int s = 0; s < NUM_SLOTS; s++)
          if (held_valid[s] && held_index[s] == prev_idx[c])
            still_held = 1'b1;
        if (!still_held) begin
          r = '{default: '0};
          r.kind = KIND_RELEASE;
          r.release_index = prev_idx[c];
          run.push_back(r);
        end
      end
    end
    run[run.size() - 1].last_of_run = 1'b1;
    foreach (run[i])
      results_due.push_back(run[i]);
  endtask

  task automatic push_frame(input logic [15:0] idx, input logic key, input logic rl,
                            input logic rg, input logic ra, input copy_t cg,
                            input copy_t ca);
    frame_word_t f;
    f.frame_index    = idx;
    f.key_frame      = key;
    f.refresh_last   = rl;
    f.refresh_golden = rg;
    f.refresh_alt    = ra;
    f.copy_to_golden = cg;
    f.copy_to_alt    = ca;
    // every third run of 25 frames goes back to back
    f.gap = ((frame_q.size() / 25) % 3 == 2) ? 0 : $urandom_range(0, MAX_WAIT);
    frame_q.push_back(f);
  endtask

  task automatic check_result();
    result_word_t want;
    if (results_due.size() == 0) begin
      report_mismatch("result with nothing due", out_release_index, 16'h0);
      return;
    end
    want = results_due.pop_front();
    if (out_result_kind !== want.kind)
      report_mismatch("result_kind", out_result_kind, want.kind);
    if (out_status !== want.status)
      report_mismatch("status", out_status, want.status);
    if (out_ref_last !== want.ref_last)
      report_mismatch("ref_last", out_ref_last, want.ref_last);
    if (out_ref_golden !== want.ref_golden)
      report_mismatch("ref_golden", out_ref_golden, want.ref_golden);
    if (out_ref_alt !== want.ref_alt)
      report_mismatch("ref_alt", out_ref_alt, want.ref_alt);
    if (out_release_index !== want.release_index)
      report_mismatch("release_index", out_release_index, want.release_index);
    if (out_last_of_run !== want.last_of_run)
      report_mismatch("last_of_run", out_last_of_run, want.last_of_run);
  endtask

  // frame driver: holds a word until it is taken, then waits out the next
  // word's gap before offering it
  frame_word_t on_wire;
  frame_word_t next_frame;
  logic        staged = 1'b0;
  int          tx_wait = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      for (int s = 0; s < NUM_SLOTS; s++) begin
        held_valid[s] = 1'b0;
        held_index[s] = '0;
      end
    end else begin
      if (in_valid && in_ready) begin
        predict_frame(on_wire);
        frames_taken++;
      end
      // a word that is still waiting keeps valid and payload as they are
      if (!(in_valid && !in_ready)) begin
        if (!staged && frame_q.size() > 0) begin
          next_frame = frame_q.pop_front();
          staged = 1'b1;
          tx_wait = next_frame.gap;
        end
        if (staged && tx_wait == 0) begin
          in_frame_index    <= next_frame.frame_index;
          in_key_frame      <= next_frame.key_frame;
          in_refresh_last   <= next_frame.refresh_last;
          in_refresh_golden <= next_frame.refresh_golden;
          in_refresh_alt    <= next_frame.refresh_alt;
          in_copy_to_golden <= next_frame.copy_to_golden;
          in_copy_to_alt    <= next_frame.copy_to_alt;
          in_valid          <= 1'b1;
          on_wire = next_frame;
          staged = 1'b0;
        end else begin
          if (staged)
            tx_wait--;
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: checks each taken word, then draws its own stall
  int rx_wait = 0;
  int hold_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        check_result();
        results_seen++;
        // every third run of 40 results is taken without stalls
        rx_wait = ((results_seen / 40) % 3 == 1) ? 0 : $urandom_range(0, MAX_WAIT);
        // one long hold-off so the block backs up and stalls its input
        if (results_seen == HOLD_AT_RESULT)
          hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // hang detection: cycles in a row with no word moving on either side
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  initial begin
    int          k;
    int          pick;
    logic [15:0] idx;

    // inter frames straight after reset have no last reference
    push_frame(16'hFFFF, 1'b0, 1'b1, 1'b1, 1'b1, COPY_RSVD, COPY_RSVD);
    push_frame(16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, COPY_NONE, COPY_NONE);
    // key frame into empty slots refers to itself, refresh and copy ignored
    push_frame(16'hA5A5, 1'b1, 1'b1, 1'b1, 1'b1, COPY_OTHER, COPY_LAST);
    // key frame over full slots releases the same index three times
    push_frame(16'hFFFF, 1'b1, 1'b0, 1'b0, 1'b0, COPY_NONE, COPY_NONE);
    // inter frame that touches nothing releases itself
    push_frame(16'h0001, 1'b0, 1'b0, 1'b0, 1'b0, COPY_NONE, COPY_NONE);
    // refresh one slot at a time
    push_frame(16'h0002, 1'b0, 1'b1, 1'b0, 1'b0, COPY_NONE, COPY_NONE);
    push_frame(16'h0003, 1'b0, 1'b0, 1'b1, 1'b0, COPY_NONE, COPY_NONE);
    push_frame(16'h0004, 1'b0, 1'b0, 1'b0, 1'b1, COPY_NONE, COPY_NONE);
    // both copy sources, each way round
    push_frame(16'h0005, 1'b0, 1'b0, 1'b0, 1'b0, COPY_LAST, COPY_OTHER);
    push_frame(16'h0006, 1'b0, 1'b0, 1'b0, 1'b0, COPY_OTHER, COPY_LAST);
    // refresh beats copy
    push_frame(16'h0007, 1'b0, 1'b0, 1'b1, 1'b1, COPY_LAST, COPY_OTHER);
    // reserved copy code acts as no copy
    push_frame(16'h0008, 1'b0, 1'b0, 1'b0, 1'b0, COPY_RSVD, COPY_RSVD);
    // refresh all three, three old slots go
    push_frame(16'h8000, 1'b0, 1'b1, 1'b1, 1'b1, COPY_NONE, COPY_NONE);
    push_frame(16'h0000, 1'b1, 1'b0, 1'b1, 1'b0, COPY_RSVD, COPY_NONE);
    // copy reads the old last while last is refreshed
    push_frame(16'h1234, 1'b0, 1'b1, 1'b0, 1'b0, COPY_LAST, COPY_LAST);
    // key frame reusing an index already held
    push_frame(16'h1234, 1'b1, 1'b0, 1'b0, 1'b0, COPY_NONE, COPY_NONE);
    push_frame(16'h5A5A, 1'b0, 1'b0, 1'b0, 1'b0, COPY_NONE, COPY_NONE);
    push_frame(16'hFFFF, 1'b0, 1'b1, 1'b0, 1'b1, COPY_OTHER, COPY_RSVD);

    // random frames, indices mostly from a small pool so slots collide often
    for (k = 0; k < RANDOM_FRAMES; k++) begin
      pick = $urandom_range(0, 3);
      idx = (pick == 0) ? 16'($urandom()) : 16'($urandom_range(0, 9));
      push_frame(idx, $urandom_range(0, 7) == 0, 1'($urandom_range(0, 1)),
                 $urandom_range(0, 2) == 0, $urandom_range(0, 2) == 0,
                 copy_t'($urandom_range(0, 3)), copy_t'($urandom_range(0, 3)));
    end
    n_frames = frame_q.size();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // sampled on the falling edge, clear of the clocked processes
    while (frames_taken < n_frames || results_due.size() != 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (err_cnt == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule
